/* hw/rtl/kcs_pkg.sv */
// Shared types and constants of the keyframe clip sampler.
`default_nettype none
package kcs_pkg;

    typedef enum logic [1:0] {
        MODE_LOAD_TIME  = 2'd0,
        MODE_LOAD_VALUE = 2'd1,
        MODE_SAMPLE     = 2'd2,
        MODE_UNUSED     = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        CFG_KEY_COUNT     = 2'd0,
        CFG_LOOP_ENABLE   = 2'd1,
        CFG_CLIP_DURATION = 2'd2,
        CFG_NONE          = 2'd3
    } cfg_idx_t;

    localparam logic [6:0]  KEY_COUNT_RST     = 7'd1;
    localparam logic        LOOP_ENABLE_RST   = 1'b1;
    localparam logic [22:0] CLIP_DURATION_RST = 23'd65536;

    // channels per part: rotation xyz then position xyz
    localparam int LANES_PER_PART = 6;
    localparam int AXES           = 3;
    localparam int FRAC_BITS      = 16;

    localparam int REM_W = 34;     // divide-step remainder
    localparam int DIV_W = 33;     // divide-step divisor

endpackage
`default_nettype wire

/* hw/rtl/kcs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module kcs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

/* hw/rtl/kcs_divstep.sv */
// One restoring divide step: shift in a bit, compare, conditionally subtract.
`default_nettype none
module kcs_divstep (
    input  wire logic [kcs_pkg::REM_W-1:0] rem_in,
    input  wire logic                      bit_in,
    input  wire logic [kcs_pkg::DIV_W-1:0] divisor,
    output logic      [kcs_pkg::REM_W-1:0] rem_out,
    output logic                           q_bit
);

    logic [kcs_pkg::REM_W-1:0] shifted;
    logic [kcs_pkg::REM_W-1:0] div_ext;

    assign shifted = {rem_in[kcs_pkg::REM_W-2:0], bit_in};
    assign div_ext = {1'b0, divisor};
    assign q_bit   = (shifted >= div_ext);
    assign rem_out = q_bit ? (shifted - div_ext) : shifted;

endmodule
`default_nettype wire

/* hw/rtl/keyframe_clip_sampler_unit.sv */
// Top level of the keyframe clip sampler: key tables, sequencer and output stage.
// A sample transaction wraps the time when looping, scans the key times,
// divides for the blend weight when needed, then blends every channel and
// waits on output stalls; its pace is set by the bit-serial divide step and
// the single read port of the value RAM (two reads per channel). One sample
// at a time.
// aresetn is synchronous, active low; RAM contents are not cleared.
`default_nettype none
module keyframe_clip_sampler_unit #(
    parameter int MAX_KEYS   = 64,
    parameter int PART_COUNT = 6
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [5:0] frame_index, [11:6] channel_index, [43:12] load_value,
    // [75:44] query_time, [79:76] zero
    input  wire logic [79:0] s_tdata,
    // [1:0] mode
    input  wire logic [1:0]  s_tuser,
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [2:0] part_index, [4:3] axis, [36:5] out_value, [39:37] zero
    output logic      [39:0] m_tdata,
    // [0] vector_kind
    output logic      [0:0]  m_tuser,
    output logic             m_tlast
);

    localparam int CHANNELS = PART_COUNT * kcs_pkg::LANES_PER_PART;
    localparam int KW  = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int NW  = $clog2(MAX_KEYS + 1);
    localparam int VW  = $clog2(MAX_KEYS * CHANNELS);
    localparam int CHW = $clog2(CHANNELS);
    localparam int PW  = (PART_COUNT > 1) ? $clog2(PART_COUNT) : 1;
    localparam int ONE_Q16 = 1 << kcs_pkg::FRAC_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_MOD, S_MFIX, S_K_FIRST, S_K_FIRST_CHK, S_K_LAST_CHK,
        S_SCAN_RD, S_SCAN_CHK, S_FRAC, S_CH_A, S_CH_B, S_CH_M, S_CH_O
    } state_t;

    // configuration registers
    logic [6:0]  key_count_reg;
    logic        loop_enable_reg;
    logic [22:0] clip_duration_reg;

    state_t state_reg;

    // input field views
    logic [5:0]         in_fi;
    logic [5:0]         in_ch;
    logic signed [31:0] in_lv;
    logic signed [31:0] in_qt;
    kcs_pkg::mode_t     in_mode;

    assign in_fi   = s_tdata[5:0];
    assign in_ch   = s_tdata[11:6];
    assign in_lv   = s_tdata[43:12];
    assign in_qt   = s_tdata[75:44];
    assign in_mode = kcs_pkg::mode_t'(s_tuser);

    logic in_acc;
    assign s_tready  = (state_reg == S_IDLE);
    assign in_acc    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // key count in use, clipped to the table size
    logic [NW-1:0] n_keys;
    logic [KW-1:0] last_key;
    assign n_keys   = (32'(key_count_reg) > MAX_KEYS) ? NW'(MAX_KEYS)
                                                       : NW'(key_count_reg);
    assign last_key = KW'(n_keys - NW'(1));

    // sequencer registers
    logic signed [31:0]        t_reg;          // wrapped or clamped time
    logic                      t_neg_reg;
    logic [31:0]               dvd_reg;        // |time| shifted out MSB first
    logic [kcs_pkg::REM_W-1:0] rem_reg;
    logic [kcs_pkg::DIV_W-1:0] div_reg;
    logic [4:0]                cnt_reg;
    logic signed [31:0]        k0_reg;
    logic signed [31:0]        prev_reg;       // time of the key below hi
    logic [KW-1:0]             lo_reg;
    logic [KW-1:0]             hi_reg;
    logic [16:0]               u_reg;          // Q1.16 blend weight, up to 1.0
    logic                      zero_reg;       // no keys: emit zeros
    logic [CHW-1:0]            chan_reg;
    logic [PW-1:0]             part_reg;
    logic                      kind_reg;
    logic [1:0]                axis_reg;
    logic signed [31:0]        a_reg;
    logic signed [50:0]        prod_reg;

    // output stage
    logic        m_valid_reg;
    logic [39:0] m_data_reg;
    logic        m_kind_reg;
    logic        m_last_reg;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

    // shared divide-step unit: time wrap and blend weight
    logic [kcs_pkg::REM_W-1:0] step_rem;
    logic                      step_q;

    kcs_divstep u_divstep (
        .rem_in  (rem_reg),
        .bit_in  ((state_reg == S_MOD) ? dvd_reg[31] : 1'b0),
        .divisor (div_reg),
        .rem_out (step_rem),
        .q_bit   (step_q)
    );

    // key time table
    logic               kt_we;
    logic [KW-1:0]      kt_raddr;
    logic signed [31:0] kt_rdata;

    assign kt_we = in_acc && (in_mode == kcs_pkg::MODE_LOAD_TIME)
                   && (32'(in_fi) < MAX_KEYS);

    always_comb begin
        unique case (state_reg)
            S_K_FIRST_CHK: kt_raddr = last_key;
            S_SCAN_RD:     kt_raddr = hi_reg;
            default:       kt_raddr = '0;
        endcase
    end

    kcs_ram #(.WIDTH(32), .DEPTH(MAX_KEYS)) u_key_times (
        .aclk  (aclk),
        .we    (kt_we),
        .waddr (KW'(in_fi)),
        .wdata (in_lv),
        .raddr (kt_raddr),
        .rdata (kt_rdata)
    );

    // key value table, row per key, channel within the row
    logic               kv_we;
    logic [VW-1:0]      kv_waddr;
    logic [VW-1:0]      kv_raddr;
    logic signed [31:0] kv_rdata;

    assign kv_we    = in_acc && (in_mode == kcs_pkg::MODE_LOAD_VALUE)
                      && (32'(in_fi) < MAX_KEYS) && (32'(in_ch) < CHANNELS);
    assign kv_waddr = VW'(32'(in_fi) * CHANNELS + 32'(in_ch));
    assign kv_raddr = (state_reg == S_CH_A)
                      ? VW'(32'(lo_reg) * CHANNELS + 32'(chan_reg))
                      : VW'(32'(hi_reg) * CHANNELS + 32'(chan_reg));

    kcs_ram #(.WIDTH(32), .DEPTH(MAX_KEYS * CHANNELS)) u_key_values (
        .aclk  (aclk),
        .we    (kv_we),
        .waddr (kv_waddr),
        .wdata (in_lv),
        .raddr (kv_raddr),
        .rdata (kv_rdata)
    );

    // datapath helpers
    logic signed [32:0] span_w;     // candidate key span
    logic signed [32:0] diff_w;     // time past the lower key
    logic signed [32:0] ab_diff;
    logic signed [50:0] rnd_w;
    logic signed [31:0] blend_w;
    logic               out_free;
    logic               out_load;

    assign span_w   = {kt_rdata[31], kt_rdata} - {prev_reg[31], prev_reg};
    assign diff_w   = {t_reg[31], t_reg} - {prev_reg[31], prev_reg};
    assign ab_diff  = {kv_rdata[31], kv_rdata} - {a_reg[31], a_reg};
    assign rnd_w    = prod_reg + 51'sd32768;
    assign blend_w  = zero_reg ? 32'sd0 : (a_reg + rnd_w[47:16]);
    assign out_free = !m_valid_reg || m_tready;
    assign out_load = (state_reg == S_CH_O) && out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= S_IDLE;
            m_valid_reg       <= 1'b0;
            key_count_reg     <= kcs_pkg::KEY_COUNT_RST;
            loop_enable_reg   <= kcs_pkg::LOOP_ENABLE_RST;
            clip_duration_reg <= kcs_pkg::CLIP_DURATION_RST;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (kcs_pkg::cfg_idx_t'(cfg_index))
                    kcs_pkg::CFG_KEY_COUNT:     key_count_reg     <= cfg_data[6:0];
                    kcs_pkg::CFG_LOOP_ENABLE:   loop_enable_reg   <= cfg_data[0];
                    kcs_pkg::CFG_CLIP_DURATION: clip_duration_reg <= cfg_data[22:0];
                    default: ;
                endcase
            end

            // a new result reloads the output stage below
            if (m_valid_reg && m_tready && !out_load) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (in_acc && (in_mode == kcs_pkg::MODE_SAMPLE)) begin
                        chan_reg <= '0;
                        part_reg <= '0;
                        kind_reg <= 1'b0;
                        axis_reg <= '0;
                        zero_reg <= 1'b0;
                        u_reg    <= '0;
                        if (loop_enable_reg && (clip_duration_reg != '0)) begin
                            t_neg_reg <= in_qt[31];
                            dvd_reg   <= in_qt[31] ? (32'd0 - 32'(in_qt)) : 32'(in_qt);
                            rem_reg   <= '0;
                            div_reg   <= kcs_pkg::DIV_W'(clip_duration_reg);
                            cnt_reg   <= '0;
                            state_reg <= S_MOD;
                        end else begin
                            if (in_qt > $signed({9'd0, clip_duration_reg})) begin
                                t_reg <= $signed({9'd0, clip_duration_reg});
                            end else if (in_qt < 0) begin
                                t_reg <= '0;
                            end else begin
                                t_reg <= in_qt;
                            end
                            state_reg <= S_K_FIRST;
                        end
                    end
                end
                S_MOD: begin
                    rem_reg <= step_rem;
                    dvd_reg <= {dvd_reg[30:0], 1'b0};
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd31) begin
                        state_reg <= S_MFIX;
                    end
                end
                S_MFIX: begin
                    // remainder takes the sign of the time; fold into [0, d)
                    if (t_neg_reg && (rem_reg[22:0] != '0)) begin
                        t_reg <= $signed({9'd0, clip_duration_reg - rem_reg[22:0]});
                    end else begin
                        t_reg <= $signed({9'd0, rem_reg[22:0]});
                    end
                    state_reg <= S_K_FIRST;
                end
                S_K_FIRST: begin
                    if (n_keys == '0) begin
                        zero_reg  <= 1'b1;
                        lo_reg    <= '0;
                        hi_reg    <= '0;
                        state_reg <= S_CH_A;
                    end else begin
                        state_reg <= S_K_FIRST_CHK;
                    end
                end
                S_K_FIRST_CHK: begin
                    k0_reg <= kt_rdata;
                    if (t_reg <= kt_rdata) begin
                        lo_reg    <= '0;
                        hi_reg    <= '0;
                        state_reg <= S_CH_A;
                    end else begin
                        state_reg <= S_K_LAST_CHK;
                    end
                end
                S_K_LAST_CHK: begin
                    if (t_reg >= kt_rdata) begin
                        lo_reg    <= last_key;
                        hi_reg    <= last_key;
                        state_reg <= S_CH_A;
                    end else begin
                        // strictly inside: the scan stops by the last key
                        hi_reg    <= KW'(1);
                        prev_reg  <= k0_reg;
                        state_reg <= S_SCAN_RD;
                    end
                end
                S_SCAN_RD: begin
                    state_reg <= S_SCAN_CHK;
                end
                S_SCAN_CHK: begin
                    if (kt_rdata >= t_reg) begin
                        lo_reg <= hi_reg - KW'(1);
                        if (span_w <= 0) begin
                            u_reg     <= '0;
                            state_reg <= S_CH_A;
                        end else if (diff_w == span_w) begin
                            u_reg     <= 17'(ONE_Q16);
                            state_reg <= S_CH_A;
                        end else begin
                            rem_reg   <= kcs_pkg::REM_W'(diff_w);
                            div_reg   <= kcs_pkg::DIV_W'(span_w);
                            cnt_reg   <= '0;
                            state_reg <= S_FRAC;
                        end
                    end else begin
                        prev_reg  <= kt_rdata;
                        hi_reg    <= hi_reg + KW'(1);
                        state_reg <= S_SCAN_RD;
                    end
                end
                S_FRAC: begin
                    rem_reg <= step_rem;
                    u_reg   <= {u_reg[15:0], step_q};
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd15) begin
                        state_reg <= S_CH_A;
                    end
                end
                S_CH_A: begin
                    state_reg <= S_CH_B;
                end
                S_CH_B: begin
                    a_reg     <= kv_rdata;
                    state_reg <= S_CH_M;
                end
                S_CH_M: begin
                    prod_reg  <= ab_diff * $signed({1'b0, u_reg});
                    state_reg <= S_CH_O;
                end
                S_CH_O: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {3'd0, blend_w, axis_reg, 3'(part_reg)};
                        m_kind_reg  <= kind_reg;
                        m_last_reg  <= (32'(chan_reg) == CHANNELS - 1);
                        if (32'(chan_reg) == CHANNELS - 1) begin
                            state_reg <= S_IDLE;
                        end else begin
                            chan_reg <= chan_reg + CHW'(1);
                            if (axis_reg == 2'(kcs_pkg::AXES - 1)) begin
                                axis_reg <= '0;
                                kind_reg <= !kind_reg;
                                if (kind_reg) begin
                                    part_reg <= part_reg + PW'(1);
                                end
                            end else begin
                                axis_reg <= axis_reg + 2'd1;
                            end
                            state_reg <= S_CH_A;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // remainder of the divide step stays below its divisor
    a_rem_below_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FRAC) |-> (rem_reg < {1'b0, div_reg}))
        else $error("blend weight remainder not below span");

    // blend weight never exceeds one
    a_weight_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CH_M) |-> (u_reg <= 17'(ONE_Q16)))
        else $error("blend weight above one");

    // the marked result carries the final part and axis
    a_last_position: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_last_reg) |->
            ((m_data_reg[2:0] == 3'(PART_COUNT - 1)) && (m_data_reg[4:3] == 2'd2)
             && m_kind_reg))
        else $error("last flag on wrong channel");

endmodule
`default_nettype wire
